// File: rtl/sfrb_pkg.sv
// Shared constants, codes and types for the slotted frame ring buffer.
package sfrb_pkg;

   localparam int unsigned SLOTS      = 8192;
   localparam int unsigned SLOT_W     = 13;
   localparam int unsigned PTR_W      = SLOT_W + 1;
   localparam int unsigned LEN_W      = 23;
   localparam int unsigned MLEN_W     = 24;
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned SIZE_W     = 10;
   localparam int unsigned SPAN_W     = 16;
   localparam int unsigned DCNT_W     = 5;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = 10'd256;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = 10'd512;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd256;
   localparam logic [MLEN_W-1:0] LEN_INVALID = 24'hFFFFFF;

   typedef enum logic [2:0] {
      FUNC_WRITE      = 3'd0,
      FUNC_READ       = 3'd1,
      FUNC_START      = 3'd2,
      FUNC_STOP       = 3'd3,
      FUNC_RESET      = 3'd4,
      FUNC_RESET_DISC = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_DROPPED    = 3'd1,
      ST_CLOSED     = 3'd2,
      ST_TOO_SMALL  = 3'd3,
      ST_EMPTY_WAIT = 3'd4,
      ST_EMPTY_STOP = 3'd5
   } status_type;

   typedef enum logic [14:0] {
      S_CLEAR   = 15'b000000000000001,
      S_IDLE    = 15'b000000000000010,
      S_DIV     = 15'b000000000000100,
      S_WR_MUL  = 15'b000000000001000,
      S_WR_FIT  = 15'b000000000010000,
      S_WR_TAIL = 15'b000000000100000,
      S_SCAN_A  = 15'b000000001000000,
      S_SCAN_D  = 15'b000000010000000,
      S_CHK_A   = 15'b000000100000000,
      S_CHK_D   = 15'b000001000000000,
      S_WR_MARK = 15'b000010000000000,
      S_RD_A    = 15'b000100000000000,
      S_RD_D    = 15'b001000000000000,
      S_RD_CLR  = 15'b010000000000000,
      S_OUT     = 15'b100000000000000
   } state_type;

   // clamp the slot size register to its usable range
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] v;
      v = raw;
      if (raw < SIZE_MIN) v = SIZE_MIN;
      else if (raw > SIZE_MAX) v = SIZE_MAX;
      return v;
   endfunction

   function automatic logic holds_frame(input logic [MLEN_W-1:0] len);
      return (len != '0) && (len != LEN_INVALID);
   endfunction

endpackage

// File: rtl/sfrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfrb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/slotted_frame_ring_buffer.sv
// Slotted frame ring buffer: descriptor manager with a shared divider and sweep sequencer.
//
//   channel  | handshake            | payload
//   req      | req_valid/req_stall  | func, frame_length, frame_time, frame_eos,
//            |                      | frame_discontinuity, reader_capacity
//   rsp      | rsp_valid/rsp_stall  | status, slot_index, byte_count, stored_time
//   csr      | csr_write_enable     | csr_write_data (slot size)
//
// One beat at a time. A write of a multi-slot frame, and a read that finds a
// frame, run the bit-serial divider; a beat may also sweep the descriptor
// RAMs slot by slot (marking, clearing, skipping or scanning for a frame).
// After reset, and on either reset function, a clearing pass over all 8192
// slots zeroes the RAMs while req_stall stays high. A stalled result does not
// block acceptance of the next request beat.
module slotted_frame_ring_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_func,
   input  logic [sfrb_pkg::LEN_W-1:0]          req_frame_length,
   input  logic [sfrb_pkg::TIME_W-1:0]         req_frame_time,
   input  logic                                req_frame_eos,
   input  logic                                req_frame_discontinuity,
   input  logic [sfrb_pkg::LEN_W-1:0]          req_reader_capacity,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [sfrb_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic [sfrb_pkg::LEN_W-1:0]          rsp_byte_count,
   output logic [sfrb_pkg::TIME_W-1:0]         rsp_stored_time,
   input  logic                                csr_write_enable,
   input  logic [sfrb_pkg::SIZE_W-1:0]         csr_write_data
);

   localparam int unsigned SW  = sfrb_pkg::SLOT_W;
   localparam int unsigned PW  = sfrb_pkg::PTR_W;
   localparam int unsigned LW  = sfrb_pkg::LEN_W;
   localparam int unsigned MW  = sfrb_pkg::MLEN_W;
   localparam int unsigned TW  = sfrb_pkg::TIME_W;
   localparam int unsigned ZW  = sfrb_pkg::SIZE_W;
   localparam int unsigned NW  = sfrb_pkg::SPAN_W;
   localparam int unsigned CW  = sfrb_pkg::DCNT_W;
   localparam logic [PW-1:0] LAST_PTR  = PW'(sfrb_pkg::SLOTS - 1);
   localparam logic [PW-1:0] SLOTS_PTR = PW'(sfrb_pkg::SLOTS);
   localparam logic [NW-1:0] SLOTS_N   = NW'(sfrb_pkg::SLOTS);
   localparam logic [CW-1:0] DIV_LAST  = CW'(LW - 1);

   sfrb_pkg::state_type state_ff, state_in;

   logic [ZW-1:0] cfg_size_ff, cfg_size_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic          running_ff, running_in;
   logic          await_ff, await_in;

   logic          is_write_ff, is_write_in;
   logic [LW-1:0] len_ff, len_in;
   logic [TW-1:0] time_ff, time_in;
   logic          eos_ff, eos_in;
   logic [LW-1:0] cap_ff, cap_in;

   logic [LW-1:0] dq_ff, dq_in;
   logic [ZW:0]   rem_ff, rem_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [NW-1:0] slots_ff, slots_in;
   logic [SW-1:0] w_ff, w_in;
   logic [MW-1:0] prod_ff, prod_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] end_ff, end_in;
   logic [PW-1:0] skips_ff, skips_in;
   logic          clr_rsp_ff, clr_rsp_in;

   logic [2:0]    res_status_ff, res_status_in;
   logic [SW-1:0] res_index_ff, res_index_in;
   logic [LW-1:0] res_count_ff, res_count_in;
   logic [TW-1:0] res_time_ff, res_time_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [SW-1:0] rsp_index_ff, rsp_index_in;
   logic [LW-1:0] rsp_count_ff, rsp_count_in;
   logic [TW-1:0] rsp_time_ff, rsp_time_in;

   // descriptor RAM ports
   logic          len_we, stamp_we, flag_we;
   logic [SW-1:0] ram_waddr, ram_raddr;
   logic [MW-1:0] len_wdata, len_rdata;
   logic [TW-1:0] stamp_wdata, stamp_rdata;
   logic          flag_wdata, flag_rdata;

   logic [ZW-1:0] ss;
   logic [ZW:0]   rem_trial;
   logic          div_bit;
   logic [NW-1:0] span_end;
   logic [PW-1:0] span_clip;
   logic          rs_hit;

   sfrb_ram #(.WIDTH(MW), .DEPTH(sfrb_pkg::SLOTS)) u_len_ram (
      .clock  (clock),
      .wr_en  (len_we),
      .wr_addr(ram_waddr),
      .wr_data(len_wdata),
      .rd_addr(ram_raddr),
      .rd_data(len_rdata)
   );

   sfrb_ram #(.WIDTH(TW), .DEPTH(sfrb_pkg::SLOTS)) u_stamp_ram (
      .clock  (clock),
      .wr_en  (stamp_we),
      .wr_addr(ram_waddr),
      .wr_data(stamp_wdata),
      .rd_addr(ram_raddr),
      .rd_data(stamp_rdata)
   );

   sfrb_ram #(.WIDTH(1), .DEPTH(sfrb_pkg::SLOTS)) u_flag_ram (
      .clock  (clock),
      .wr_en  (flag_we),
      .wr_addr(ram_waddr),
      .wr_data(flag_wdata),
      .rd_addr(ram_raddr),
      .rd_data(flag_rdata)
   );

   assign ss        = sfrb_pkg::eff_size(cfg_size_ff);
   assign rem_trial = {rem_ff[ZW-1:0], dq_ff[LW-1]};
   assign div_bit   = rem_trial >= {1'b0, ss};
   assign span_end  = {{(NW-SW){1'b0}}, w_ff} + slots_ff;
   assign span_clip = (span_end > SLOTS_N) ? SLOTS_PTR : span_end[PW-1:0];
   assign rs_hit    = (w_ff <= rslot_ff) &&
                      ({{(NW-SW){1'b0}}, rslot_ff} < span_end);

   assign req_stall = (state_ff != sfrb_pkg::S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cfg_size_in   = cfg_size_ff;
      wslot_in      = wslot_ff;
      rslot_in      = rslot_ff;
      running_in    = running_ff;
      await_in      = await_ff;
      is_write_in   = is_write_ff;
      len_in        = len_ff;
      time_in       = time_ff;
      eos_in        = eos_ff;
      cap_in        = cap_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      slots_in      = slots_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      skips_in      = skips_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_count_in  = res_count_ff;
      res_time_in   = res_time_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_time_in   = rsp_time_ff;

      len_we      = 1'b0;
      stamp_we    = 1'b0;
      flag_we     = 1'b0;
      ram_waddr   = ptr_ff[SW-1:0];
      ram_raddr   = ptr_ff[SW-1:0];
      len_wdata   = '0;
      stamp_wdata = '0;
      flag_wdata  = 1'b0;

      if (csr_write_enable) begin
         cfg_size_in = csr_write_data;
      end

      unique case (state_ff)
         sfrb_pkg::S_CLEAR: begin
            len_we   = 1'b1;
            stamp_we = 1'b1;
            flag_we  = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            if (ptr_ff == LAST_PTR) begin
               wslot_in = '0;
               rslot_in = '0;
               state_in = clr_rsp_ff ? sfrb_pkg::S_OUT : sfrb_pkg::S_IDLE;
            end
         end

         sfrb_pkg::S_IDLE: begin
            if (req_valid) begin
               is_write_in   = (req_func == sfrb_pkg::FUNC_WRITE);
               len_in        = req_frame_length;
               time_in       = req_frame_time;
               eos_in        = req_frame_eos;
               cap_in        = req_reader_capacity;
               res_status_in = sfrb_pkg::ST_OK;
               res_index_in  = '0;
               res_count_in  = '0;
               res_time_in   = '0;
               state_in      = sfrb_pkg::S_OUT;
               case (req_func)
                  sfrb_pkg::FUNC_WRITE: begin
                     w_in = wslot_ff;
                     if (!running_ff || (req_frame_length > {ss, {SW{1'b0}}})) begin
                        res_status_in = sfrb_pkg::ST_DROPPED;
                     end else if (req_frame_discontinuity) begin
                        await_in      = 1'b0;
                        res_status_in = sfrb_pkg::ST_DROPPED;
                     end else if (await_ff) begin
                        res_status_in = sfrb_pkg::ST_DROPPED;
                     end else if (req_frame_length > LW'(ss)) begin
                        dq_in    = req_frame_length;
                        rem_in   = '0;
                        dcnt_in  = '0;
                        state_in = sfrb_pkg::S_DIV;
                     end else begin
                        slots_in = NW'(1);
                        state_in = sfrb_pkg::S_CHK_A;
                     end
                  end
                  sfrb_pkg::FUNC_READ: begin
                     skips_in = '0;
                     state_in = sfrb_pkg::S_RD_A;
                  end
                  sfrb_pkg::FUNC_START: begin
                     running_in = 1'b1;
                     await_in   = 1'b0;
                  end
                  sfrb_pkg::FUNC_STOP: begin
                     running_in = 1'b0;
                  end
                  sfrb_pkg::FUNC_RESET: begin
                     ptr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = sfrb_pkg::S_CLEAR;
                  end
                  sfrb_pkg::FUNC_RESET_DISC: begin
                     await_in   = 1'b1;
                     ptr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = sfrb_pkg::S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // restoring divide of len_ff by the slot size, one quotient bit a cycle
         sfrb_pkg::S_DIV: begin
            rem_in  = div_bit ? (rem_trial - {1'b0, ss}) : rem_trial;
            dq_in   = {dq_ff[LW-2:0], div_bit};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) begin
               slots_in = dq_in[NW-1:0] + 1'b1;
               if (is_write_ff) begin
                  state_in = sfrb_pkg::S_WR_MUL;
               end else begin
                  ptr_in   = {1'b0, w_ff};
                  state_in = sfrb_pkg::S_RD_CLR;
               end
            end
         end

         sfrb_pkg::S_WR_MUL: begin
            prod_in  = MW'(SLOTS_PTR - {1'b0, w_ff}) * MW'(ss);
            state_in = sfrb_pkg::S_WR_FIT;
         end

         sfrb_pkg::S_WR_FIT: begin
            ptr_in = {1'b0, w_ff};
            if ({1'b0, len_ff} > prod_ff) begin
               state_in = sfrb_pkg::S_WR_TAIL;
            end else begin
               state_in = sfrb_pkg::S_CHK_A;
            end
         end

         // mark the ring tail invalid, then move the reader if the frame lands on it
         sfrb_pkg::S_WR_TAIL: begin
            len_we    = 1'b1;
            len_wdata = sfrb_pkg::LEN_INVALID;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_PTR) begin
               w_in = '0;
               if (rs_hit) begin
                  rslot_in = '0;
                  ptr_in   = '0;
                  state_in = sfrb_pkg::S_SCAN_A;
               end else begin
                  state_in = sfrb_pkg::S_CHK_A;
               end
            end
         end

         sfrb_pkg::S_SCAN_A: begin
            state_in = sfrb_pkg::S_SCAN_D;
         end

         sfrb_pkg::S_SCAN_D: begin
            if (sfrb_pkg::holds_frame(len_rdata)) begin
               rslot_in = ptr_ff[SW-1:0];
               state_in = sfrb_pkg::S_CHK_A;
            end else if (ptr_ff == LAST_PTR) begin
               state_in = sfrb_pkg::S_CHK_A;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = sfrb_pkg::S_SCAN_A;
            end
         end

         sfrb_pkg::S_CHK_A: begin
            ram_raddr = rslot_ff;
            state_in  = sfrb_pkg::S_CHK_D;
         end

         // store the head descriptor, advance the writer, and move the reader past a frame it overwrites
         sfrb_pkg::S_CHK_D: begin
            ram_waddr   = w_ff;
            len_we      = 1'b1;
            stamp_we    = 1'b1;
            flag_we     = 1'b1;
            len_wdata   = eos_ff ? '0 : {1'b0, len_ff};
            stamp_wdata = eos_ff ? '0 : time_ff;
            flag_wdata  = eos_ff;
            wslot_in    = span_end[SW-1:0];
            if (rs_hit && sfrb_pkg::holds_frame(len_rdata)) begin
               rslot_in = span_end[SW-1:0];
            end
            res_status_in = sfrb_pkg::ST_OK;
            res_index_in  = w_ff;
            res_count_in  = eos_ff ? '0 : len_ff;
            res_time_in   = eos_ff ? '0 : time_ff;
            ptr_in        = {1'b0, w_ff} + 1'b1;
            end_in        = span_clip;
            if (({1'b0, w_ff} + 1'b1) < span_clip) begin
               state_in = sfrb_pkg::S_WR_MARK;
            end else begin
               state_in = sfrb_pkg::S_OUT;
            end
         end

         sfrb_pkg::S_WR_MARK: begin
            len_we    = 1'b1;
            len_wdata = sfrb_pkg::LEN_INVALID;
            ptr_in    = ptr_ff + 1'b1;
            if ((ptr_ff + 1'b1) == end_ff) begin
               state_in = sfrb_pkg::S_OUT;
            end
         end

         sfrb_pkg::S_RD_A: begin
            ram_raddr = rslot_ff;
            state_in  = sfrb_pkg::S_RD_D;
         end

         sfrb_pkg::S_RD_D: begin
            res_index_in = rslot_ff;
            res_count_in = '0;
            res_time_in  = '0;
            state_in     = sfrb_pkg::S_OUT;
            if (flag_rdata) begin
               res_status_in = sfrb_pkg::ST_CLOSED;
            end else if (sfrb_pkg::holds_frame(len_rdata)) begin
               if ({1'b0, cap_ff} < len_rdata) begin
                  res_status_in = sfrb_pkg::ST_TOO_SMALL;
                  res_count_in  = len_rdata[LW-1:0];
               end else begin
                  w_in     = rslot_ff;
                  len_in   = len_rdata[LW-1:0];
                  time_in  = stamp_rdata;
                  dq_in    = len_rdata[LW-1:0];
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = sfrb_pkg::S_DIV;
               end
            end else if ((len_rdata == sfrb_pkg::LEN_INVALID) && (skips_ff < SLOTS_PTR)) begin
               // skip an invalid slot
               rslot_in = rslot_ff + 1'b1;
               skips_in = skips_ff + 1'b1;
               state_in = sfrb_pkg::S_RD_A;
            end else begin
               res_status_in = running_ff ? sfrb_pkg::ST_EMPTY_WAIT
                                          : sfrb_pkg::ST_EMPTY_STOP;
            end
         end

         // free the slots of the frame just read
         sfrb_pkg::S_RD_CLR: begin
            len_we   = 1'b1;
            stamp_we = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            if ((ptr_ff + 1'b1) == span_clip) begin
               rslot_in      = span_end[SW-1:0];
               res_status_in = sfrb_pkg::ST_OK;
               res_index_in  = w_ff;
               res_count_in  = len_ff;
               res_time_in   = time_ff;
               state_in      = sfrb_pkg::S_OUT;
            end
         end

         sfrb_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_count_in  = res_count_ff;
               rsp_time_in   = res_time_ff;
               clr_rsp_in    = 1'b0;
               state_in      = sfrb_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sfrb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfrb_pkg::S_CLEAR;
         cfg_size_ff  <= sfrb_pkg::SIZE_RESET;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         running_ff   <= 1'b0;
         await_ff     <= 1'b0;
         ptr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_size_ff  <= cfg_size_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         running_ff   <= running_in;
         await_ff     <= await_in;
         ptr_ff       <= ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_write_ff   <= is_write_in;
      len_ff        <= len_in;
      time_ff       <= time_in;
      eos_ff        <= eos_in;
      cap_ff        <= cap_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      slots_ff      <= slots_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      end_ff        <= end_in;
      skips_ff      <= skips_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_count_ff  <= res_count_in;
      res_time_ff   <= res_time_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_time_ff   <= rsp_time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_stored_time = rsp_time_ff;

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfrb_pkg::S_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfrb_pkg::S_DIV) |-> (dcnt_ff <= DIV_LAST))
      else $error("divider ran past its last step");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= sfrb_pkg::ST_EMPTY_STOP))
      else $error("result status out of range");

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfrb_pkg::S_RD_D) |-> (skips_ff <= SLOTS_PTR))
      else $error("skip count beyond ring size");

endmodule

// File: tb/tb_top.sv
// Testbench for the slotted frame ring buffer: directed and random beats checked against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS  = sfrb_pkg::SLOTS;
   localparam int unsigned SLOT_W = sfrb_pkg::SLOT_W;
   localparam int unsigned LEN_W  = sfrb_pkg::LEN_W;
   localparam int unsigned MLEN_W = sfrb_pkg::MLEN_W;
   localparam int unsigned TIME_W = sfrb_pkg::TIME_W;
   localparam int unsigned SIZE_W = sfrb_pkg::SIZE_W;

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam logic [LEN_W-1:0] LEN_TOP = 23'd4194304;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot_index;
      logic [LEN_W-1:0]  byte_count;
      logic [TIME_W-1:0] stored_time;
   } frame_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_func;
   logic [LEN_W-1:0]    req_frame_length;
   logic [TIME_W-1:0]   req_frame_time;
   logic                req_frame_eos;
   logic                req_frame_discontinuity;
   logic [LEN_W-1:0]    req_reader_capacity;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [2:0]          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [LEN_W-1:0]    rsp_byte_count;
   logic [TIME_W-1:0]   rsp_stored_time;
   logic                csr_write_enable;
   logic [SIZE_W-1:0]   csr_write_data;

   // predictor state
   logic [MLEN_W-1:0]   ring_len [SLOTS];
   logic [TIME_W-1:0]   ring_stamp [SLOTS];
   bit                  ring_end [SLOTS];
   int unsigned         wr_slot;
   int unsigned         rd_slot;
   bit                  is_running;
   bit                  awaiting_disc;
   logic [SIZE_W-1:0]   slot_size_reg;

   frame_rsp_type       expected_rsp [$];
   int                  mismatch_count;
   int                  tx_idle_pct;
   int                  rx_idle_pct;
   int                  hold_left;

   slotted_frame_ring_buffer DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_func                (req_func),
      .req_frame_length        (req_frame_length),
      .req_frame_time          (req_frame_time),
      .req_frame_eos           (req_frame_eos),
      .req_frame_discontinuity (req_frame_discontinuity),
      .req_reader_capacity     (req_reader_capacity),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_byte_count          (rsp_byte_count),
      .rsp_stored_time         (rsp_stored_time),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void clear_ring();
      for (int i = 0; i < SLOTS; i++) begin
         ring_len[i] = '0;
         ring_stamp[i] = '0;
         ring_end[i] = 1'b0;
      end
      wr_slot = 0;
      rd_slot = 0;
   endfunction

   function automatic bit slot_has_frame(int unsigned i);
      return ring_len[i] != '0 && ring_len[i] != sfrb_pkg::LEN_INVALID;
   endfunction

   function automatic longint unsigned clamped_size();
      if (slot_size_reg < sfrb_pkg::SIZE_MIN) return 64'(sfrb_pkg::SIZE_MIN);
      if (slot_size_reg > sfrb_pkg::SIZE_MAX) return 64'(sfrb_pkg::SIZE_MAX);
      return 64'(slot_size_reg);
   endfunction

   function automatic frame_rsp_type make_rsp(sfrb_pkg::status_type st, longint unsigned idx,
                                              longint unsigned cnt, logic [TIME_W-1:0] t);
      frame_rsp_type r;
      r.status = st;
      r.slot_index = idx[SLOT_W-1:0];
      r.byte_count = cnt[LEN_W-1:0];
      r.stored_time = t;
      return r;
   endfunction

   function automatic frame_rsp_type predict_write(logic [LEN_W-1:0] len,
                                                   logic [TIME_W-1:0] tm,
                                                   logic eos, logic disc);
      longint unsigned ss, span, stop_at, w, flen;
      bit multi, clobber;
      ss = clamped_size();
      flen = 64'(len);
      span = 1;
      multi = 1'b0;
      w = 64'(wr_slot);
      if (!is_running || flen > SLOTS * ss) return make_rsp(sfrb_pkg::ST_DROPPED, 0, 0, '0);
      if (disc) begin
         awaiting_disc = 1'b0;
         return make_rsp(sfrb_pkg::ST_DROPPED, 0, 0, '0);
      end
      if (awaiting_disc) return make_rsp(sfrb_pkg::ST_DROPPED, 0, 0, '0);
      if (flen > ss) begin
         multi = 1'b1;
         span = flen / ss + 1;
      end
      // wrap: invalidate the tail, move the reader if the frame lands on it
      if (multi && flen > (SLOTS - w) * ss) begin
         for (longint unsigned i = w; i < SLOTS; i++) ring_len[i] = sfrb_pkg::LEN_INVALID;
         if (w <= rd_slot && rd_slot < w + span) begin
            rd_slot = 0;
            for (int unsigned i = 0; i < SLOTS; i++) begin
               if (slot_has_frame(i)) begin
                  rd_slot = i;
                  break;
               end
            end
         end
         w = 0;
      end
      clobber = w <= rd_slot && rd_slot < w + span && slot_has_frame(rd_slot);
      ring_len[w] = eos ? '0 : {1'b0, len};
      ring_stamp[w] = eos ? '0 : tm;
      ring_end[w] = eos;
      stop_at = w + span;
      if (stop_at > SLOTS) stop_at = SLOTS;
      for (longint unsigned i = w + 1; i < stop_at; i++) ring_len[i] = sfrb_pkg::LEN_INVALID;
      wr_slot = 32'((w + span) % SLOTS);
      if (clobber) rd_slot = wr_slot;
      return make_rsp(sfrb_pkg::ST_OK, w, 64'(ring_len[w]), ring_stamp[w]);
   endfunction

   function automatic frame_rsp_type predict_read(logic [LEN_W-1:0] cap);
      longint unsigned ss, flen, span, stop_at, r;
      logic [TIME_W-1:0] t;
      int unsigned skips;
      ss = clamped_size();
      skips = 0;
      while (1'b1) begin
         r = 64'(rd_slot);
         if (ring_end[r]) return make_rsp(sfrb_pkg::ST_CLOSED, r, 0, '0);
         if (slot_has_frame(32'(r))) begin
            flen = 64'(ring_len[r]);
            if (64'(cap) < flen) return make_rsp(sfrb_pkg::ST_TOO_SMALL, r, flen, '0);
            span = flen / ss + 1;
            t = ring_stamp[r];
            stop_at = r + span;
            if (stop_at > SLOTS) stop_at = SLOTS;
            for (longint unsigned i = r; i < stop_at; i++) begin
               ring_len[i] = '0;
               ring_stamp[i] = '0;
            end
            rd_slot = 32'((r + span) % SLOTS);
            return make_rsp(sfrb_pkg::ST_OK, r, flen, t);
         end
         if (ring_len[r] == sfrb_pkg::LEN_INVALID && skips < SLOTS) begin
            rd_slot = 32'((r + 1) % SLOTS);
            skips++;
            continue;
         end
         return make_rsp(is_running ? sfrb_pkg::ST_EMPTY_WAIT : sfrb_pkg::ST_EMPTY_STOP,
                         r, 0, '0);
      end
      return make_rsp(sfrb_pkg::ST_OK, 0, 0, '0);
   endfunction

   function automatic frame_rsp_type predict_ring(logic [2:0] func, logic [LEN_W-1:0] len,
                                                  logic [TIME_W-1:0] tm, logic eos, logic disc,
                                                  logic [LEN_W-1:0] cap);
      case (func)
         sfrb_pkg::FUNC_WRITE: return predict_write(len, tm, eos, disc);
         sfrb_pkg::FUNC_READ:  return predict_read(cap);
         sfrb_pkg::FUNC_START: begin
            is_running = 1'b1;
            awaiting_disc = 1'b0;
         end
         sfrb_pkg::FUNC_STOP: is_running = 1'b0;
         sfrb_pkg::FUNC_RESET: clear_ring();
         sfrb_pkg::FUNC_RESET_DISC: begin
            awaiting_disc = 1'b1;
            clear_ring();
         end
         default: ;
      endcase
      return make_rsp(sfrb_pkg::ST_OK, 0, 0, '0);
   endfunction

   // one request beat, with a random gap in front of it
   task automatic send_item(logic [2:0] func, logic [LEN_W-1:0] len, logic [TIME_W-1:0] tm,
                            logic eos, logic disc, logic [LEN_W-1:0] cap);
      int gap;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func = func;
      req_frame_length = len;
      req_frame_time = tm;
      req_frame_eos = eos;
      req_frame_discontinuity = disc;
      req_reader_capacity = cap;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_ring(func, len, tm, eos, disc, cap));
      @(negedge clock);
   endtask

   task automatic go_quiet();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_slot_size(logic [SIZE_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      slot_size_reg = value;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 999);
      if (r < 10) return '0;
      if (r < 700) return LEN_W'($urandom_range(1, 1100));
      if (r < 980) return LEN_W'($urandom_range(1100, 40000));
      if (r < 995) return LEN_W'($urandom_range(40000, 2100000));
      return LEN_W'($urandom_range(2097000, LEN_TOP));
   endfunction

   function automatic logic [LEN_W-1:0] pick_capacity();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LEN_TOP;
      if (r < 85) return LEN_W'($urandom_range(0, LEN_TOP));
      return LEN_W'($urandom_range(0, 2000));
   endfunction

   task automatic send_random_item();
      int r;
      logic [TIME_W-1:0] t;
      t = {$urandom, $urandom};
      r = $urandom_range(0, 999);
      if (r < 430)
         send_item(sfrb_pkg::FUNC_WRITE, pick_length(), t, $urandom_range(0, 99) < 2, 1'b0, '0);
      else if (r < 450)
         send_item(sfrb_pkg::FUNC_WRITE, pick_length(), t, 1'b0, 1'b1, '0);
      else if (r < 860)
         send_item(sfrb_pkg::FUNC_READ, pick_length(), t, 1'($urandom), 1'($urandom),
                   pick_capacity());
      else if (r < 920)
         send_item(sfrb_pkg::FUNC_START, '0, '0, 1'b0, 1'b0, '0);
      else if (r < 950)
         send_item(sfrb_pkg::FUNC_STOP, '0, '0, 1'b0, 1'b0, '0);
      else if (r < 970)
         send_item(sfrb_pkg::FUNC_RESET, '0, '0, 1'b0, 1'b0, '0);
      else if (r < 985)
         send_item(sfrb_pkg::FUNC_RESET_DISC, '0, '0, 1'b0, 1'b0, '0);
      else
         send_item(r[0] ? FUNC_SPARE_A : FUNC_SPARE_B, pick_length(), t, 1'($urandom),
                   1'($urandom), pick_capacity());
   endtask

   task automatic test_directed();
      logic [TIME_W-1:0] ones;
      ones = '1;
      write_slot_size(sfrb_pkg::SIZE_MIN);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd100, 64'd5, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_START, '0, '0, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd256, ones, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd257, 64'd7, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_WRITE, 23'h7FFF, 64'd9, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, 23'd257);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd40, ones, 1'b1, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, 23'h7FFFFF);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(FUNC_SPARE_A, LEN_TOP, ones, 1'b1, 1'b1, 23'h7FFFFF);
      send_item(FUNC_SPARE_B, '0, '0, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_RESET_DISC, '0, '0, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd10, 64'd1, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_WRITE, '0, '0, 1'b0, 1'b1, '0);
      send_item(sfrb_pkg::FUNC_WRITE, LEN_TOP, ones, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_WRITE, 23'd600, 64'd3, 1'b0, 1'b0, '0);
      // exactly the ring's capacity: wraps and clips the marking at the last slot
      send_item(sfrb_pkg::FUNC_WRITE, 23'd2097152, 64'd4, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_STOP, '0, '0, 1'b0, 1'b0, '0);
      send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      send_item(sfrb_pkg::FUNC_RESET, '0, '0, 1'b0, 1'b0, '0);
      go_quiet();
   endtask

   task automatic test_random_phase(int tx_pct, int rx_pct, int count,
                                    logic [SIZE_W-1:0] size_a, logic [SIZE_W-1:0] size_b);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_slot_size(size_a);
      send_item(sfrb_pkg::FUNC_START, '0, '0, 1'b0, 1'b0, '0);
      repeat (count / 2) send_random_item();
      go_quiet();
      write_slot_size(size_b);
      send_item(sfrb_pkg::FUNC_START, '0, '0, 1'b0, 1'b0, '0);
      repeat (count / 2) send_random_item();
      go_quiet();
   endtask

   // hold the result side off while the request side keeps pushing beats
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_left = 300;
      send_item(sfrb_pkg::FUNC_START, '0, '0, 1'b0, 1'b0, '0);
      repeat (20) begin
         send_item(sfrb_pkg::FUNC_WRITE, LEN_W'($urandom_range(1, 700)), {$urandom, $urandom},
                   1'b0, 1'b0, '0);
         send_item(sfrb_pkg::FUNC_READ, '0, '0, 1'b0, 1'b0, LEN_TOP);
      end
      go_quiet();
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = $urandom_range(0, 99) < rx_idle_pct;
      end
   end

   always @(posedge clock) begin
      frame_rsp_type got;
      frame_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_slot_index, rsp_byte_count, rsp_stored_time};
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.slot_index !== want.slot_index ||
                got.byte_count !== want.byte_count || got.stored_time !== want.stored_time) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected st=%0d idx=%0d cnt=%0d t=%h, got st=%0d idx=%0d cnt=%0d t=%h",
                           want.status, want.slot_index, want.byte_count, want.stored_time,
                           got.status, got.slot_index, got.byte_count, got.stored_time);
            end
         end
      end
   end

   initial begin
      #400_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      hold_left = 0;
      tx_idle_pct = 33;
      rx_idle_pct = 52;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = sfrb_pkg::FUNC_START;
      req_frame_length = '0;
      req_frame_time = '0;
      req_frame_eos = 1'b0;
      req_frame_discontinuity = 1'b0;
      req_reader_capacity = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      slot_size_reg = sfrb_pkg::SIZE_RESET;
      is_running = 1'b0;
      awaiting_disc = 1'b0;
      clear_ring();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phase(33, 52, 400, sfrb_pkg::SIZE_MAX, 10'd0);
      test_random_phase(52, 33, 400, 10'h3FF, 10'd300);
      test_random_phase(0, 0, 400, 10'd511, 10'd257);
      test_backpressure();

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: slotted_frame_ring_buffer.f
rtl/sfrb_pkg.sv
rtl/sfrb_ram.sv
rtl/slotted_frame_ring_buffer.sv
tb/tb_top.sv
